>>> sv/lfpd_pkg.sv
// Shared types, constants and helpers for the line follower PID drive block.
`default_nettype none

package lfpd_pkg;

	// Configuration port geometry and register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_MIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_MAX  = 3'd5;

	// Field widths.
	localparam int GAIN_W    = 16;
	localparam int SPEED_W   = 8;
	localparam int POS_W     = 10;
	localparam int ERR_W     = 10;
	localparam int DIFF_W    = 11;
	localparam int FRAC_BITS = 16;

	// Reset values of the configuration registers.
	localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 16'd6554;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 16'd52;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 16'd39322;
	localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 8'd125;
	localparam logic [SPEED_W-1:0] BASE_MIN_RST  = 8'd25;
	localparam logic [SPEED_W-1:0] BASE_MAX_RST  = 8'd100;

	localparam int BASE_OFFSET = 25;

	typedef logic [POS_W-1:0]         pos_t;
	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic signed [DIFF_W-1:0] diff_t;

	// Line positions for the recognized sensor patterns.
	localparam pos_t POS_LEFT         = 10'd0;
	localparam pos_t POS_LEFT_CENTER  = 10'd175;
	localparam pos_t POS_CENTER       = 10'd350;
	localparam pos_t POS_RIGHT_CENTER = 10'd525;
	localparam pos_t POS_RIGHT        = 10'd700;

	// Sensor patterns as {left, center, right}.
	localparam logic [2:0] PAT_LEFT         = 3'b100;
	localparam logic [2:0] PAT_LEFT_CENTER  = 3'b110;
	localparam logic [2:0] PAT_CENTER       = 3'b010;
	localparam logic [2:0] PAT_RIGHT_CENTER = 3'b011;
	localparam logic [2:0] PAT_RIGHT        = 3'b001;

	// Map a sensor pattern to a line position; other patterns keep the old one.
	function automatic pos_t decode_pos(input logic [2:0] pattern, input pos_t prev);
		pos_t pos;
		unique case (pattern)
			PAT_LEFT:         pos = POS_LEFT;
			PAT_LEFT_CENTER:  pos = POS_LEFT_CENTER;
			PAT_CENTER:       pos = POS_CENTER;
			PAT_RIGHT_CENTER: pos = POS_RIGHT_CENTER;
			PAT_RIGHT:        pos = POS_RIGHT;
			default:          pos = prev;
		endcase
		return pos;
	endfunction

endpackage

`default_nettype wire

>>> sv/lfpd_if.sv
// Valid/ready channel interfaces for sensor ticks and wheel commands.
`default_nettype none

interface lfpd_tick_if #(parameter int DISTANCE_WIDTH = 12);
	logic                      valid;
	logic                      ready;
	logic                      button_pressed;
	logic                      line_left;
	logic                      line_center;
	logic                      line_right;
	logic [DISTANCE_WIDTH-1:0] distance_mm;

	modport source (output valid, button_pressed, line_left, line_center, line_right,
		distance_mm, input ready);
	modport sink (input valid, button_pressed, line_left, line_center, line_right,
		distance_mm, output ready);
endinterface

interface lfpd_cmd_if;
	import lfpd_pkg::*;
	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] left_speed;
	logic [SPEED_W-1:0] right_speed;

	modport source (output valid, left_speed, right_speed, input ready);
	modport sink (input valid, left_speed, right_speed, output ready);
endinterface

`default_nettype wire

>>> sv/line_follow_pid_drive.sv
// Line follower with distance-based base speed and PID steering for a differential drive.
`default_nettype none

// Each accepted tick that yields a command passes the stage 1 to stage 6 registers in order.
// Throughput: one tick per cycle while cmd.ready does not stall, set by the six-register single-pass pipeline.
// Mode, position and PID state are read and written in the first stage, once per tick.
// A press tick toggles the mode and gives no command; an off tick gives zero speeds.
// Reset (arst_n low, asynchronous) empties the pipeline, sets the mode off, clears the
// integral and last error, centers the position and loads the default gains and limits.
module line_follow_pid_drive #(
	parameter int INTEGRAL_WIDTH = 24,
	parameter int DISTANCE_WIDTH = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	lfpd_tick_if.sink                        tick,
	lfpd_cmd_if.source                       cmd,
	input  logic                             cfg_we,
	input  logic [lfpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lfpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lfpd_pkg::*;

	localparam int IW      = INTEGRAL_WIDTH;
	localparam int BASE_W  = DISTANCE_WIDTH + 1;
	localparam int P_W     = ERR_W + GAIN_W + 1;
	localparam int I_W     = IW + GAIN_W + 1;
	localparam int D_W     = DIFF_W + GAIN_W + 1;
	localparam int SUM_W   = IW + GAIN_W + 3;
	localparam int CORR_W  = SUM_W - FRAC_BITS;
	localparam int WHEEL_W = CORR_W + 1;

	// Configuration registers.
	logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic [SPEED_W-1:0] max_speed_q, base_min_q, base_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= GAIN_P_RST;
			gain_i_q    <= GAIN_I_RST;
			gain_d_q    <= GAIN_D_RST;
			max_speed_q <= MAX_SPEED_RST;
			base_min_q  <= BASE_MIN_RST;
			base_max_q  <= BASE_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:    gain_p_q    <= cfg_data;
				REG_GAIN_I:    gain_i_q    <= cfg_data;
				REG_GAIN_D:    gain_d_q    <= cfg_data;
				REG_MAX_SPEED: max_speed_q <= cfg_data[SPEED_W-1:0];
				REG_BASE_MIN:  base_min_q  <= cfg_data[SPEED_W-1:0];
				REG_BASE_MAX:  base_max_q  <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage valids and the backward advance chain.
	logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	// Stage 1 transaction fields.
	logic                      press_s1;
	logic [2:0]                pattern_s1;
	logic [DISTANCE_WIDTH-1:0] dist_s1;

	assign adv6 = !v6_q || cmd.ready;
	assign adv5 = !v5_q || adv6;
	assign adv4 = !v4_q || adv5;
	assign adv3 = !v3_q || adv4;
	assign adv2 = !v2_q || adv3;
	assign adv1 = !v1_q || adv2;

	assign tick.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			v6_q <= 1'b0;
		end else begin
			if (adv1) v1_q <= tick.valid;
			if (adv2) v2_q <= v1_q && !press_s1;
			if (adv3) v3_q <= v2_q;
			if (adv4) v4_q <= v3_q;
			if (adv5) v5_q <= v4_q;
			if (adv6) v6_q <= v5_q;
		end
	end

	// Stage 1: registered tick transaction.
	always_ff @(posedge clk) begin
		if (adv1 && tick.valid) begin
			press_s1   <= tick.button_pressed;
			pattern_s1 <= {tick.line_left, tick.line_center, tick.line_right};
			dist_s1    <= tick.distance_mm;
		end
	end

	// Controller state.
	logic           driving_q;
	pos_t           prev_pos_q;
	err_t           prev_err_q;
	logic [IW-1:0]  esum_q;

	// Stage 1 logic: position, error, saturated integral, difference, base speed.
	logic            fire1;
	pos_t            pos_n;
	logic [DIFF_W-1:0] err_wide;
	err_t            err_n;
	logic [IW:0]     esum_wide;
	logic [IW-1:0]   esum_n;
	diff_t           diff_n;
	logic [BASE_W-1:0] base_raw;
	logic [SPEED_W-1:0] base_n;

	assign fire1 = v1_q && adv2;

	always_comb begin
		pos_n    = decode_pos(pattern_s1, prev_pos_q);
		err_wide = {1'b0, POS_CENTER} - {1'b0, pos_n};
		err_n    = err_t'(err_wide[ERR_W-1:0]);

		esum_wide = {esum_q[IW-1], esum_q} + {{(IW + 1 - ERR_W){err_n[ERR_W-1]}}, err_n};
		if (esum_wide[IW] != esum_wide[IW-1]) begin
			esum_n = esum_wide[IW] ? {1'b1, {(IW - 1){1'b0}}} : {1'b0, {(IW - 1){1'b1}}};
		end else begin
			esum_n = esum_wide[IW-1:0];
		end

		diff_n = diff_t'({err_n[ERR_W-1], err_n} - {prev_err_q[ERR_W-1], prev_err_q});

		base_raw = ({1'b0, dist_s1} >> 1) + BASE_W'(BASE_OFFSET);
		if (base_raw > {{(BASE_W - SPEED_W){1'b0}}, base_max_q}) begin
			base_n = base_max_q;
		end else begin
			base_n = base_raw[SPEED_W-1:0];
		end
		if (base_n < base_min_q) begin
			base_n = base_min_q;
		end
	end

	// State update, once for each tick leaving stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			driving_q  <= 1'b0;
			prev_pos_q <= POS_CENTER;
			prev_err_q <= '0;
			esum_q     <= '0;
		end else if (fire1) begin
			if (press_s1) begin
				driving_q <= !driving_q;
			end else if (driving_q) begin
				prev_pos_q <= pos_n;
				prev_err_q <= err_n;
				esum_q     <= esum_n;
			end
		end
	end

	// Stage 2: PID operands.
	logic               drive_s2;
	err_t               err_s2;
	logic [IW-1:0]      esum_s2;
	diff_t              diff_s2;
	logic [SPEED_W-1:0] base_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			drive_s2 <= driving_q;
			err_s2   <= err_n;
			esum_s2  <= esum_n;
			diff_s2  <= diff_n;
			base_s2  <= base_n;
		end
	end

	// Stage 3: the three gain products.
	logic signed [P_W-1:0] prod_p, prod_p_s3;
	logic signed [I_W-1:0] prod_i, prod_i_s3;
	logic signed [D_W-1:0] prod_d, prod_d_s3;
	logic                  drive_s3;
	logic [SPEED_W-1:0]    base_s3;

	always_comb begin
		prod_p = $signed({{(P_W - ERR_W){err_s2[ERR_W-1]}}, err_s2})
			* $signed({{(P_W - GAIN_W){1'b0}}, gain_p_q});
		prod_i = $signed({{(I_W - IW){esum_s2[IW-1]}}, esum_s2})
			* $signed({{(I_W - GAIN_W){1'b0}}, gain_i_q});
		prod_d = $signed({{(D_W - DIFF_W){diff_s2[DIFF_W-1]}}, diff_s2})
			* $signed({{(D_W - GAIN_W){1'b0}}, gain_d_q});
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			prod_p_s3 <= prod_p;
			prod_i_s3 <= prod_i;
			prod_d_s3 <= prod_d;
			drive_s3  <= drive_s2;
			base_s3   <= base_s2;
		end
	end

	// Stage 4: sum of the products.
	logic signed [SUM_W-1:0] sum_s4;
	logic                    drive_s4;
	logic [SPEED_W-1:0]      base_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			sum_s4 <= $signed({{(SUM_W - P_W){prod_p_s3[P_W-1]}}, prod_p_s3})
				+ $signed({{(SUM_W - I_W){prod_i_s3[I_W-1]}}, prod_i_s3})
				+ $signed({{(SUM_W - D_W){prod_d_s3[D_W-1]}}, prod_d_s3});
			drive_s4 <= drive_s3;
			base_s4  <= base_s3;
		end
	end

	// Stage 5: drop the fraction, rounding toward zero.
	logic [SUM_W-1:0]   sum_biased;
	logic [CORR_W-1:0]  corr_s5;
	logic               drive_s5;
	logic [SPEED_W-1:0] base_s5;

	assign sum_biased = sum_s4
		+ {{(SUM_W - FRAC_BITS){1'b0}}, {FRAC_BITS{sum_s4[SUM_W-1]}}};

	always_ff @(posedge clk) begin
		if (adv5) begin
			corr_s5  <= sum_biased[SUM_W-1:FRAC_BITS];
			drive_s5 <= drive_s4;
			base_s5  <= base_s4;
		end
	end

	// Stage 6: wheel commands, clamped to 0..max_speed, into the output register.
	logic signed [WHEEL_W-1:0] left_wide, right_wide, base_wide, corr_wide, max_wide;
	logic [SPEED_W-1:0]        left_n, right_n;
	logic [SPEED_W-1:0]        left_s6, right_s6;

	always_comb begin
		base_wide  = $signed({{(WHEEL_W - SPEED_W){1'b0}}, base_s5});
		corr_wide  = $signed({corr_s5[CORR_W-1], corr_s5});
		max_wide   = $signed({{(WHEEL_W - SPEED_W){1'b0}}, max_speed_q});
		left_wide  = base_wide + corr_wide;
		right_wide = base_wide - corr_wide;

		priority if (!drive_s5) begin
			left_n = '0;
		end else if (left_wide > max_wide) begin
			left_n = max_speed_q;
		end else if (left_wide[WHEEL_W-1]) begin
			left_n = '0;
		end else begin
			left_n = left_wide[SPEED_W-1:0];
		end

		priority if (!drive_s5) begin
			right_n = '0;
		end else if (right_wide > max_wide) begin
			right_n = max_speed_q;
		end else if (right_wide[WHEEL_W-1]) begin
			right_n = '0;
		end else begin
			right_n = right_wide[SPEED_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			left_s6  <= left_n;
			right_s6 <= right_n;
		end
	end

	assign cmd.valid       = v6_q;
	assign cmd.left_speed  = left_s6;
	assign cmd.right_speed = right_s6;

endmodule

`default_nettype wire

>>> sv/lfpd_checker.sv
// Port-level assertions for the line follower PID drive block, with its bind.
`default_nettype none

module lfpd_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             tick_valid,
	input  logic                             tick_ready,
	input  logic                             cmd_valid,
	input  logic                             cmd_ready,
	input  logic [lfpd_pkg::SPEED_W-1:0]     left_speed,
	input  logic [lfpd_pkg::SPEED_W-1:0]     right_speed,
	input  logic                             cfg_we,
	input  logic [lfpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lfpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lfpd_pkg::*;

	// Largest speed limit held since reset; every command must stay at or below it.
	logic [SPEED_W-1:0] max_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_seen_q <= MAX_SPEED_RST;
		end else if (cfg_we && cfg_index == REG_MAX_SPEED
				&& cfg_data[SPEED_W-1:0] > max_seen_q) begin
			max_seen_q <= cfg_data[SPEED_W-1:0];
		end
	end

	// A stalled command transaction stays offered.
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid)
		else $error("command valid dropped while stalled");

	// A stalled command keeps its speeds.
	a_cmd_stable: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> $stable(left_speed) && $stable(right_speed))
		else $error("command payload changed while stalled");

	// With no command waiting an offered tick is always taken.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && !cmd_valid |-> tick_ready)
		else $error("tick refused while no command is pending");

	// Wheel commands never exceed the largest speed limit held since reset.
	a_speed_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> left_speed <= max_seen_q && right_speed <= max_seen_q)
		else $error("wheel command above the speed limit");

endmodule

bind line_follow_pid_drive lfpd_checker u_lfpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.tick_valid  (tick.valid),
	.tick_ready  (tick.ready),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.left_speed  (cmd.left_speed),
	.right_speed (cmd.right_speed),
	.cfg_we      (cfg_we),
	.cfg_index   (cfg_index),
	.cfg_data    (cfg_data)
);

`default_nettype wire
